// File: src/rieu_pkg.sv
// Shared types for the integer execute unit: decoded operation codes,
// the decoded request and the result record. No dependencies.
`timescale 1ns / 1ps
package rieu_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned OutDepth   = 2;
  localparam int unsigned NumRegs    = 16;

  typedef enum logic [5:0] {
    OP_LOAD, OP_CLRT, OP_SETT, OP_SETS, OP_DIV0U, OP_MOVT, OP_MULL,
    OP_DIV0S, OP_TST, OP_CMPSTR, OP_XTRCT, OP_MULUW, OP_MULSW,
    OP_CMPEQ, OP_CMPHS, OP_CMPGE, OP_CMPHI, OP_CMPGT, OP_DIV1,
    OP_DMULU, OP_DMULS, OP_ADDC, OP_SUBC, OP_SHAD, OP_SHLD,
    OP_SHLL, OP_SHLR, OP_SHAR, OP_ROTL, OP_ROTR, OP_ROTCL, OP_ROTCR,
    OP_DT, OP_CMPPZ, OP_CMPPL, OP_NOT, OP_SWAPB, OP_SWAPW, OP_NEGC,
    OP_NEG, OP_EXTUB, OP_EXTUW, OP_EXTSB, OP_EXTSW, OP_CMPIM, OP_TSTIM,
    OP_BAD
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [3:0]  n;
    logic [3:0]  m;
    logic [7:0]  imm;
    logic [31:0] data;
  } dec_t;

  typedef struct packed {
    logic [3:0]  written_index;
    logic [31:0] written_value;
    logic        wrote_register;
    logic        t_bit;
    logic        q_bit;
    logic        m_bit;
    logic [31:0] mac_high;
    logic [31:0] mac_low;
    logic        unsupported;
  } res_t;

endpackage

// File: src/rieu_fifo.sv
// Small first-in first-out queue of flip-flops, generic width and depth.
// No dependencies.
`timescale 1ns / 1ps
module rieu_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// File: src/rieu_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module rieu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// File: src/rieu_front.sv
// Front end: decodes each request into an operation code and queues it.
// Depends on rieu_pkg and rieu_fifo.
`timescale 1ns / 1ps
module rieu_front #(
  parameter int unsigned QUEUE_DEPTH = rieu_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic                kind_i,
  input  logic [15:0]         opcode_i,
  input  logic [3:0]          load_index_i,
  input  logic [31:0]         load_value_i,
  input  logic                pop_i,
  output logic                empty_o,
  output rieu_pkg::dec_t      dec_o
);
  import rieu_pkg::*;

  dec_t       dec;
  logic [3:0] top, lo;

  assign top = opcode_i[15:12];
  assign lo  = opcode_i[3:0];

  always_comb begin
    dec.op   = OP_BAD;
    dec.n    = opcode_i[11:8];
    dec.m    = opcode_i[7:4];
    dec.imm  = opcode_i[7:0];
    dec.data = load_value_i;
    if (kind_i) begin
      dec.op = OP_LOAD;
      dec.n  = load_index_i;
    end else begin
      case (top)
        4'h0: begin
          if (opcode_i == 16'h0008) dec.op = OP_CLRT;
          else if (opcode_i == 16'h0018) dec.op = OP_SETT;
          else if (opcode_i == 16'h0058) dec.op = OP_SETS;
          else if (opcode_i == 16'h0019) dec.op = OP_DIV0U;
          else if ((opcode_i & 16'hF0FF) == 16'h0029) dec.op = OP_MOVT;
          else if (lo == 4'h7) dec.op = OP_MULL;
        end
        4'h2: begin
          case (lo)
            4'h7: dec.op = OP_DIV0S;
            4'h8: dec.op = OP_TST;
            4'hC: dec.op = OP_CMPSTR;
            4'hD: dec.op = OP_XTRCT;
            4'hE: dec.op = OP_MULUW;
            4'hF: dec.op = OP_MULSW;
            default: dec.op = OP_BAD;
          endcase
        end
        4'h3: begin
          case (lo)
            4'h0: dec.op = OP_CMPEQ;
            4'h2: dec.op = OP_CMPHS;
            4'h3: dec.op = OP_CMPGE;
            4'h4: dec.op = OP_DIV1;
            4'h5: dec.op = OP_DMULU;
            4'h6: dec.op = OP_CMPHI;
            4'h7: dec.op = OP_CMPGT;
            4'hA: dec.op = OP_SUBC;
            4'hD: dec.op = OP_DMULS;
            4'hE: dec.op = OP_ADDC;
            default: dec.op = OP_BAD;
          endcase
        end
        4'h4: begin
          if (lo == 4'hC) dec.op = OP_SHAD;
          else if (lo == 4'hD) dec.op = OP_SHLD;
          else begin
            case (opcode_i[7:0])
              8'h00, 8'h20: dec.op = OP_SHLL;
              8'h01: dec.op = OP_SHLR;
              8'h21: dec.op = OP_SHAR;
              8'h04: dec.op = OP_ROTL;
              8'h05: dec.op = OP_ROTR;
              8'h24: dec.op = OP_ROTCL;
              8'h25: dec.op = OP_ROTCR;
              8'h10: dec.op = OP_DT;
              8'h11: dec.op = OP_CMPPZ;
              8'h15: dec.op = OP_CMPPL;
              default: dec.op = OP_BAD;
            endcase
          end
        end
        4'h6: begin
          case (lo)
            4'h7: dec.op = OP_NOT;
            4'h8: dec.op = OP_SWAPB;
            4'h9: dec.op = OP_SWAPW;
            4'hA: dec.op = OP_NEGC;
            4'hB: dec.op = OP_NEG;
            4'hC: dec.op = OP_EXTUB;
            4'hD: dec.op = OP_EXTUW;
            4'hE: dec.op = OP_EXTSB;
            4'hF: dec.op = OP_EXTSW;
            default: dec.op = OP_BAD;
          endcase
        end
        4'h8: begin
          if (opcode_i[11:8] == 4'h8) begin
            dec.op = OP_CMPIM;
            dec.m  = '0;
          end
        end
        4'hC: begin
          if (opcode_i[11:8] == 4'h8) begin
            dec.op = OP_TSTIM;
            dec.m  = '0;
          end
        end
        default: dec.op = OP_BAD;
      endcase
    end
  end

  rieu_fifo #(
    .WIDTH($bits(dec_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .full_o (full_o),
    .wdata_i(dec),
    .pop_i  (pop_i),
    .empty_o(empty_o),
    .rdata_o(dec_o)
  );

endmodule

// File: src/rieu_back.sv
// Back end: reads operands from the register RAM, executes one operation
// per cycle while the result queue is not full, and holds the status and MAC registers.
// Depends on rieu_pkg and rieu_ram.
`timescale 1ns / 1ps
module rieu_back #(
  parameter int unsigned NUM_REGS = rieu_pkg::NumRegs
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  rieu_pkg::dec_t q_data_i,
  output logic           q_pop_o,
  input  logic           out_full_i,
  output logic           res_push_o,
  output rieu_pkg::res_t res_o
);
  import rieu_pkg::*;

  localparam int unsigned IdxW = $clog2(NUM_REGS);

  dec_t          ex_q;
  logic          ex_valid_q;
  logic          ex_fire;
  logic [NUM_REGS-1:0] valid_q;
  logic          rvld_n_q, rvld_m_q;
  logic [31:0]   rdata_n, rdata_m;
  logic          fwd_valid_q;
  logic [IdxW-1:0] fwd_idx_q;
  logic [31:0]   fwd_val_q;
  logic          t_q, t_d, q_q, q_d, m_q, m_d;
  logic [31:0]   mach_q, mach_d, macl_q, macl_d;
  logic [31:0]   rn, rm, v;
  logic          wr, bad;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic [32:0]   sum33;
  logic [31:0]   t0, t1, x;
  logic          borrow, qnew;
  logic [4:0]    amt, rs;
  logic [IdxW-1:0] ex_n, ex_m;

  assign ex_n = ex_q.n[IdxW-1:0];
  assign ex_m = ex_q.m[IdxW-1:0];

  assign ex_fire = ex_valid_q && !out_full_i;
  assign q_pop_o = !q_empty_i && (!ex_valid_q || ex_fire);

  rieu_ram #(
    .WIDTH(32),
    .DEPTH(NUM_REGS)
  ) u_regs (
    .clk_i    (clk_i),
    .we_i     (ex_fire && wr),
    .waddr_i  (ex_n),
    .wdata_i  (v),
    .re_i     (q_pop_o),
    .raddr_a_i(q_data_i.n[IdxW-1:0]),
    .raddr_b_i(q_data_i.m[IdxW-1:0]),
    .rdata_a_o(rdata_n),
    .rdata_b_o(rdata_m)
  );

  always_comb begin
    rn = (fwd_valid_q && fwd_idx_q == ex_n) ? fwd_val_q : (rvld_n_q ? rdata_n : '0);
    rm = (fwd_valid_q && fwd_idx_q == ex_m) ? fwd_val_q : (rvld_m_q ? rdata_m : '0);
  end

  always_comb begin
    case (ex_q.op)
      OP_MULUW: begin
        mul_a = {17'b0, rn[15:0]};
        mul_b = {17'b0, rm[15:0]};
      end
      OP_MULSW: begin
        mul_a = {{17{rn[15]}}, rn[15:0]};
        mul_b = {{17{rm[15]}}, rm[15:0]};
      end
      OP_DMULS: begin
        mul_a = {rn[31], rn};
        mul_b = {rm[31], rm};
      end
      default: begin
        mul_a = {1'b0, rn};
        mul_b = {1'b0, rm};
      end
    endcase
    prod = mul_a * mul_b;
  end

  always_comb begin
    t_d    = t_q;
    q_d    = q_q;
    m_d    = m_q;
    mach_d = mach_q;
    macl_d = macl_q;
    v      = '0;
    wr     = 1'b0;
    bad    = 1'b0;
    sum33  = '0;
    t0     = {rn[30:0], t_q};
    t1     = (ex_n == ex_m) ? t0 : rm;
    x      = rn ^ rm;
    borrow = 1'b0;
    qnew   = 1'b0;
    amt    = rm[4:0];
    rs     = 5'd0 - amt;
    case (ex_q.op)
      OP_LOAD: begin
        v  = ex_q.data;
        wr = 1'b1;
      end
      OP_CLRT:  t_d = 1'b0;
      OP_SETT:  t_d = 1'b1;
      OP_SETS:  ;
      OP_DIV0U: begin
        t_d = 1'b0;
        q_d = 1'b0;
        m_d = 1'b0;
      end
      OP_MOVT: begin
        v  = {31'b0, t_q};
        wr = 1'b1;
      end
      OP_MULL, OP_MULUW, OP_MULSW: macl_d = prod[31:0];
      OP_DMULU, OP_DMULS: begin
        macl_d = prod[31:0];
        mach_d = prod[63:32];
      end
      OP_DIV0S: begin
        q_d = rn[31];
        m_d = rm[31];
        t_d = rn[31] ^ rm[31];
      end
      OP_TST:    t_d = ((rn & rm) == '0);
      OP_CMPSTR: t_d = (x[31:24] == '0) || (x[23:16] == '0) ||
                       (x[15:8] == '0) || (x[7:0] == '0);
      OP_XTRCT: begin
        v  = {rm[15:0], rn[31:16]};
        wr = 1'b1;
      end
      OP_CMPEQ: t_d = (rn == rm);
      OP_CMPHS: t_d = (rn >= rm);
      OP_CMPGE: t_d = ($signed(rn) >= $signed(rm));
      OP_CMPHI: t_d = (rn > rm);
      OP_CMPGT: t_d = ($signed(rn) > $signed(rm));
      OP_DIV1: begin
        if (q_q == m_q) begin
          sum33  = {1'b0, t0} - {1'b0, t1};
        end else begin
          sum33  = {1'b0, t0} + {1'b0, t1};
        end
        borrow = sum33[32];
        qnew   = rn[31] ^ borrow ^ m_q;
        q_d    = qnew;
        t_d    = (qnew == m_q);
        v      = sum33[31:0];
        wr     = 1'b1;
      end
      OP_ADDC: begin
        sum33 = {1'b0, rn} + {1'b0, rm} + {32'b0, t_q};
        v     = sum33[31:0];
        t_d   = sum33[32];
        wr    = 1'b1;
      end
      OP_SUBC: begin
        sum33 = {1'b0, rn} - {1'b0, rm} - {32'b0, t_q};
        v     = sum33[31:0];
        t_d   = sum33[32];
        wr    = 1'b1;
      end
      OP_SHAD, OP_SHLD: begin
        wr = 1'b1;
        if (!rm[31]) begin
          v = rn << amt;
        end else if (amt == '0) begin
          v = (ex_q.op == OP_SHAD) ? {32{rn[31]}} : '0;
        end else if (ex_q.op == OP_SHAD) begin
          v = 32'($signed(rn) >>> rs);
        end else begin
          v = rn >> rs;
        end
      end
      OP_SHLL: begin
        t_d = rn[31];
        v   = {rn[30:0], 1'b0};
        wr  = 1'b1;
      end
      OP_SHLR: begin
        t_d = rn[0];
        v   = {1'b0, rn[31:1]};
        wr  = 1'b1;
      end
      OP_SHAR: begin
        t_d = rn[0];
        v   = {rn[31], rn[31:1]};
        wr  = 1'b1;
      end
      OP_ROTL: begin
        t_d = rn[31];
        v   = {rn[30:0], rn[31]};
        wr  = 1'b1;
      end
      OP_ROTR: begin
        t_d = rn[0];
        v   = {rn[0], rn[31:1]};
        wr  = 1'b1;
      end
      OP_ROTCL: begin
        t_d = rn[31];
        v   = {rn[30:0], t_q};
        wr  = 1'b1;
      end
      OP_ROTCR: begin
        t_d = rn[0];
        v   = {t_q, rn[31:1]};
        wr  = 1'b1;
      end
      OP_DT: begin
        v   = rn - 32'd1;
        t_d = (rn == 32'd1);
        wr  = 1'b1;
      end
      OP_CMPPZ: t_d = !rn[31];
      OP_CMPPL: t_d = !rn[31] && (rn != '0);
      OP_NOT: begin
        v  = ~rm;
        wr = 1'b1;
      end
      OP_SWAPB: begin
        v  = {rm[31:16], rm[7:0], rm[15:8]};
        wr = 1'b1;
      end
      OP_SWAPW: begin
        v  = {rm[15:0], rm[31:16]};
        wr = 1'b1;
      end
      OP_NEGC: begin
        v   = 32'd0 - rm - {31'b0, t_q};
        t_d = (rm != '0) || t_q;
        wr  = 1'b1;
      end
      OP_NEG: begin
        v  = 32'd0 - rm;
        wr = 1'b1;
      end
      OP_EXTUB: begin
        v  = {24'b0, rm[7:0]};
        wr = 1'b1;
      end
      OP_EXTUW: begin
        v  = {16'b0, rm[15:0]};
        wr = 1'b1;
      end
      OP_EXTSB: begin
        v  = {{24{rm[7]}}, rm[7:0]};
        wr = 1'b1;
      end
      OP_EXTSW: begin
        v  = {{16{rm[15]}}, rm[15:0]};
        wr = 1'b1;
      end
      OP_CMPIM: t_d = (rm == {{24{ex_q.imm[7]}}, ex_q.imm});
      OP_TSTIM: t_d = ((rm & {24'b0, ex_q.imm}) == '0);
      default:  bad = 1'b1;
    endcase
  end

  always_comb begin
    res_push_o           = ex_fire;
    res_o.written_index  = wr ? ex_q.n : '0;
    res_o.written_value  = wr ? v : '0;
    res_o.wrote_register = wr;
    res_o.t_bit          = t_d;
    res_o.q_bit          = q_d;
    res_o.m_bit          = m_d;
    res_o.mac_high       = mach_d;
    res_o.mac_low        = macl_d;
    res_o.unsupported    = bad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q  <= 1'b0;
      valid_q     <= '0;
      rvld_n_q    <= 1'b0;
      rvld_m_q    <= 1'b0;
      fwd_valid_q <= 1'b0;
      fwd_idx_q   <= '0;
      fwd_val_q   <= '0;
      t_q         <= 1'b0;
      q_q         <= 1'b0;
      m_q         <= 1'b0;
      mach_q      <= '0;
      macl_q      <= '0;
    end else begin
      if (q_pop_o) begin
        ex_valid_q <= 1'b1;
        rvld_n_q   <= valid_q[q_data_i.n[IdxW-1:0]];
        rvld_m_q   <= valid_q[q_data_i.m[IdxW-1:0]];
      end else if (ex_fire) begin
        ex_valid_q <= 1'b0;
      end
      if (ex_fire) begin
        t_q    <= t_d;
        q_q    <= q_d;
        m_q    <= m_d;
        mach_q <= mach_d;
        macl_q <= macl_d;
        if (wr) begin
          valid_q[ex_n] <= 1'b1;
          fwd_valid_q   <= 1'b1;
          fwd_idx_q     <= ex_n;
          fwd_val_q     <= v;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ex_q <= q_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_o |-> !q_empty_i)
    else $error("pop from empty decode queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push_o |-> !out_full_i)
    else $error("result pushed into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && res_o.unsupported |-> !res_o.wrote_register)
    else $error("unsupported operation wrote a register");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && !res_o.wrote_register |-> res_o.written_value == '0)
    else $error("nonzero value without register write");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_fire && !q_pop_o |=> !ex_valid_q)
    else $error("execute slot not released");

endmodule

// File: src/risc_integer_execute_unit.sv
// Top level of the integer execute unit: decode queue, execute back end
// and result queue. Depends on rieu_pkg, rieu_front, rieu_back, rieu_fifo.
//
//   channel   handshake      direction   payload
//   request   push / full    in          kind, opcode, load_index, load_value
//   result    pop / empty    out         written_*, wrote_register, flags, mac_*
//
// One request per cycle sustained while no queue is full; a result reaches the ports
// through the decode queue, then register RAM read and execute, then the result queue.
// The execute stage issues one operation per cycle while it is not stalled, one 32x32 multiply.
// Reset clears all general registers, T, Q, M, MACH and MACL at once.
// A full result queue stalls execute, which backs up into the decode queue.
`timescale 1ns / 1ps
module risc_integer_execute_unit #(
  parameter int unsigned QUEUE_DEPTH = rieu_pkg::QueueDepth,
  parameter int unsigned OUT_DEPTH   = rieu_pkg::OutDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        kind_i,
  input  logic [15:0] opcode_i,
  input  logic [3:0]  load_index_i,
  input  logic [31:0] load_value_i,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  written_index_o,
  output logic [31:0] written_value_o,
  output logic        wrote_register_o,
  output logic        t_bit_o,
  output logic        q_bit_o,
  output logic        m_bit_o,
  output logic [31:0] mac_high_o,
  output logic [31:0] mac_low_o,
  output logic        unsupported_o
);
  import rieu_pkg::*;

  dec_t q_data;
  logic q_empty, q_pop;
  res_t res, res_head;
  logic res_push, out_full;

  rieu_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .kind_i      (kind_i),
    .opcode_i    (opcode_i),
    .load_index_i(load_index_i),
    .load_value_i(load_value_i),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .dec_o       (q_data)
  );

  rieu_back #(
    .NUM_REGS(NumRegs)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .out_full_i(out_full),
    .res_push_o(res_push),
    .res_o     (res)
  );

  rieu_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .full_o (out_full),
    .wdata_i(res),
    .pop_i  (pop),
    .empty_o(empty),
    .rdata_o(res_head)
  );

  assign written_index_o  = res_head.written_index;
  assign written_value_o  = res_head.written_value;
  assign wrote_register_o = res_head.wrote_register;
  assign t_bit_o          = res_head.t_bit;
  assign q_bit_o          = res_head.q_bit;
  assign m_bit_o          = res_head.m_bit;
  assign mac_high_o       = res_head.mac_high;
  assign mac_low_o        = res_head.mac_low;
  assign unsupported_o    = res_head.unsupported;

endmodule

// File: tb/tb.sv
// Self-checking testbench for risc_integer_execute_unit: drives instruction and
// register-load requests through the push/full queue and checks each result popped.
// Depends on rieu_pkg and the execute unit RTL.
`timescale 1ns / 1ps
module tb;
  import rieu_pkg::*;

  class alu_scoreboard;
    logic [31:0] gpr[16];
    logic        t, q, mb, s;
    logic [31:0] mach, macl;
    res_t        pending[$];
    int          errors;

    function new();
      foreach (gpr[i]) gpr[i] = '0;
      t = 0; q = 0; mb = 0; s = 0; mach = '0; macl = '0; errors = 0;
    endfunction

    function logic [31:0] sra32(logic [31:0] x, int sh);
      return $unsigned($signed(x) >>> sh);
    endfunction

    function void note_request(logic kind, logic [15:0] op, logic [3:0] li,
                               logic [31:0] lv);
      logic [3:0] n, m, lo;
      logic [31:0] rn, rm, v, t0, t1, x;
      logic [63:0] p;
      logic wr, bad, oldq, qm, brw;
      res_t r;
      n = op[11:8]; m = op[7:4]; lo = op[3:0];
      wr = 0; bad = 0; v = '0;
      if (kind) begin
        n = li; v = lv; wr = 1;
      end else begin
        rn = gpr[n]; rm = gpr[m];
        case (op[15:12])
          4'h0: begin
            if (op == 16'h0008) t = 0;
            else if (op == 16'h0018) t = 1;
            else if (op == 16'h0058) s = 1;
            else if (op == 16'h0019) begin q = 0; mb = 0; t = 0; end
            else if ((op & 16'hF0FF) == 16'h0029) begin v = {31'b0, t}; wr = 1; end
            else if (lo == 4'h7) macl = rn * rm;
            else bad = 1;
          end
          4'h2: case (lo)
            4'h7: begin q = rn[31]; mb = rm[31]; t = q ^ mb; end
            4'h8: t = (rn & rm) == 0;
            4'hC: begin
              x = rn ^ rm;
              t = x[31:24] == 0 || x[23:16] == 0 || x[15:8] == 0 || x[7:0] == 0;
            end
            4'hD: begin v = {rm[15:0], rn[31:16]}; wr = 1; end
            4'hE: macl = rn[15:0] * rm[15:0];
            4'hF: begin
              p = $signed({{16{rn[15]}}, rn[15:0]}) * $signed({{16{rm[15]}}, rm[15:0]});
              macl = p[31:0];
            end
            default: bad = 1;
          endcase
          4'h3: case (lo)
            4'h0: t = rn == rm;
            4'h2: t = rn >= rm;
            4'h3: t = $signed(rn) >= $signed(rm);
            4'h6: t = rn > rm;
            4'h7: t = $signed(rn) > $signed(rm);
            4'h4: begin
              oldq = q; qm = rn[31];
              t0 = {rn[30:0], t};
              t1 = (n == m) ? t0 : rm;
              if (oldq == mb) begin v = t0 - t1; brw = v > t0; end
              else begin v = t0 + t1; brw = v < t0; end
              q = qm ^ brw ^ mb; t = q == mb; wr = 1;
            end
            4'h5: begin p = {32'b0, rn} * {32'b0, rm}; {mach, macl} = p; end
            4'hD: begin
              p = $signed({{32{rn[31]}}, rn}) * $signed({{32{rm[31]}}, rm});
              {mach, macl} = p;
            end
            4'hE: begin t1 = rn + rm; v = t1 + t; t = rn > t1 || t1 > v; wr = 1; end
            4'hA: begin t1 = rn - rm; v = t1 - t; t = rn < t1 || t1 < v; wr = 1; end
            default: bad = 1;
          endcase
          4'h4: begin
            wr = 1;
            if (lo == 4'hC || lo == 4'hD) begin
              if (!rm[31]) v = rn << rm[4:0];
              else if (rm[4:0] == 0) v = (lo == 4'hC && rn[31]) ? '1 : '0;
              else if (lo == 4'hC) v = sra32(rn, 32 - rm[4:0]);
              else v = rn >> (32 - rm[4:0]);
            end else case (op[7:0])
              8'h00, 8'h20: begin t = rn[31]; v = rn << 1; end
              8'h01: begin t = rn[0]; v = rn >> 1; end
              8'h21: begin t = rn[0]; v = sra32(rn, 1); end
              8'h04: begin t = rn[31]; v = {rn[30:0], rn[31]}; end
              8'h05: begin t = rn[0]; v = {rn[0], rn[31:1]}; end
              8'h24: begin v = {rn[30:0], t}; t = rn[31]; end
              8'h25: begin v = {t, rn[31:1]}; t = rn[0]; end
              8'h10: begin v = rn - 1; t = v == 0; end
              8'h11: begin wr = 0; t = !rn[31]; end
              8'h15: begin wr = 0; t = $signed(rn) > 0; end
              default: begin wr = 0; bad = 1; end
            endcase
          end
          4'h6: begin
            wr = 1;
            case (lo)
              4'h7: v = ~rm;
              4'h8: v = {rm[31:16], rm[7:0], rm[15:8]};
              4'h9: v = {rm[15:0], rm[31:16]};
              4'hA: begin t0 = -rm; v = t0 - t; t = t0 != 0 || t0 < v; end
              4'hB: v = -rm;
              4'hC: v = {24'b0, rm[7:0]};
              4'hD: v = {16'b0, rm[15:0]};
              4'hE: v = {{24{rm[7]}}, rm[7:0]};
              4'hF: v = {{16{rm[15]}}, rm[15:0]};
              default: begin wr = 0; bad = 1; end
            endcase
          end
          4'h8: if (op[11:8] == 4'h8) t = gpr[0] == {{24{op[7]}}, op[7:0]};
                else bad = 1;
          4'hC: if (op[11:8] == 4'h8) t = (gpr[0] & {24'b0, op[7:0]}) == 0;
                else bad = 1;
          default: bad = 1;
        endcase
      end
      if (wr) gpr[n] = v;
      else begin n = 0; v = 0; end
      r.written_index = n; r.written_value = v; r.wrote_register = wr;
      r.t_bit = t; r.q_bit = q; r.m_bit = mb; r.mac_high = mach; r.mac_low = macl;
      r.unsupported = bad;
      pending.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", exp, got);
      end
    endfunction
  endclass

  logic        clk_i = 0, rst_ni = 0, push = 0, pop = 0, kind_i = 0;
  logic [15:0] opcode_i = '0;
  logic [3:0]  load_index_i = '0;
  logic [31:0] load_value_i = '0;
  logic        full, empty, wrote_register_o, t_bit_o, q_bit_o, m_bit_o, unsupported_o;
  logic [3:0]  written_index_o;
  logic [31:0] written_value_o, mac_high_o, mac_low_o;

  alu_scoreboard sb = new();
  bit   sending_done = 0;
  int   idle_cycles = 0;
  int   hold_off = 0;

  always #6 clk_i = ~clk_i;

  risc_integer_execute_unit dut (.*);

  always @(posedge clk_i) begin
    if (rst_ni && ((push && !full) || (pop && !empty))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_request(logic kind, logic [15:0] op, logic [3:0] li,
                              logic [31:0] lv);
    int gap;
    gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(14);
    if (gap > 0) begin
      push <= 0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1; kind_i <= kind; opcode_i <= op; load_index_i <= li; load_value_i <= lv;
    do @(posedge clk_i); while (full);
    sb.note_request(kind, op, li, lv);
  endtask

  function automatic logic [15:0] pick_opcode();
    logic [15:0] ops[$] = '{16'h0008, 16'h0018, 16'h0058, 16'h0019, 16'h0029,
      16'h0007, 16'h2007, 16'h2008, 16'h200C, 16'h200D, 16'h200E, 16'h200F,
      16'h3000, 16'h3002, 16'h3003, 16'h3006, 16'h3007, 16'h3004, 16'h3005,
      16'h300D, 16'h300E, 16'h300A, 16'h400C, 16'h400D, 16'h4000, 16'h4020,
      16'h4001, 16'h4021, 16'h4004, 16'h4005, 16'h4024, 16'h4025, 16'h4010,
      16'h4011, 16'h4015, 16'h6007, 16'h6008, 16'h6009, 16'h600A, 16'h600B,
      16'h600C, 16'h600D, 16'h600E, 16'h600F, 16'h8800, 16'hC800};
    logic [15:0] o;
    o = ops[$urandom_range(ops.size() - 1)];
    if (o[15:12] == 4'h8 || o[15:12] == 4'hC) o[7:0] = 8'($urandom);
    else if (o[15:12] != 4'h0 || o[3:0] == 4'h7 || o[7:0] == 8'h29) begin
      o[11:8] = 4'($urandom);
      o[7:4] = (o[15:12] == 4'h4 && o[3:0] < 4'hC) ? o[7:4] : 4'($urandom);
    end
    return o;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return $urandom_range(40);
      4: return 32'hFFFF_FFE0 | $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_request(1, 16'h0, 4'd1, 32'hFFFF_FFFF);
    send_request(1, 16'h0, 4'd2, 32'h8000_0000);
    send_request(1, 16'h0, 4'd3, 32'h8000_0000);
    send_request(0, 16'h4D3D, 0, 0);
    send_request(0, 16'h423C, 0, 0);
    send_request(0, 16'h0018, 0, 0);
    send_request(0, 16'h642A, 0, 0);
    send_request(0, 16'h600A, 0, 0);
    send_request(0, 16'h3114, 0, 0);
    send_request(0, 16'h3125, 0, 0);
    send_request(0, 16'h312D, 0, 0);
    send_request(0, 16'h0029, 0, 0);
    send_request(0, 16'h88FF, 0, 0);
    send_request(0, 16'hC8FF, 0, 0);
    send_request(0, 16'hFFFF, 0, 0);
    send_request(0, 16'h4E1B, 0, 0);
    send_request(1, 16'hFFFF, 4'd15, 32'h0000_0001);
    send_request(0, 16'h4F10, 0, 0);
    send_request(0, 16'h0019, 0, 0);
    send_request(0, 16'h2F17, 0, 0);
    send_request(0, 16'h3F34, 0, 0);
    for (int i = 0; i < 1030; i++) begin
      if (i == 400) hold_off = 150;
      case ($urandom_range(9))
        0, 1: send_request(1, 16'($urandom), 4'($urandom), pick_value());
        2: send_request(0, 16'($urandom), 4'($urandom), $urandom);
        default: send_request(0, pick_opcode(), 4'($urandom), $urandom);
      endcase
    end
    push <= 0;
    sending_done = 1;
  end

  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (hold_off > 0) begin
        pop <= 0;
        repeat (hold_off) @(posedge clk_i);
        hold_off = 0;
      end
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(14);
      if (gap > 0) begin
        pop <= 0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1;
      do @(posedge clk_i); while (empty);
      sb.check_result('{written_index_o, written_value_o, wrote_register_o, t_bit_o,
                        q_bit_o, m_bit_o, mac_high_o, mac_low_o, unsupported_o});
    end
  end

  initial begin
    wait (sending_done);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && empty) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
